/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Non-overlapping implication (|=>), checked outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/lcdws_pkg.sv */
// Package for the character LCD write sequencer.
// Holds item op codes, register indexes, register reset values and default sizes.
package lcdws_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_MAX_CHARS   = 20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int BYTE_W     = 8;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INST_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CMD   = 2'd3;

    localparam logic [TICK_W-1:0] RST_ENABLE_HIGH = 16'd10;
    localparam logic [TICK_W-1:0] RST_INST_DELAY  = 16'd40;
    localparam logic [TICK_W-1:0] RST_CLEAR_DELAY = 16'd1600;
    localparam logic [BYTE_W-1:0] RST_CLEAR_CMD   = 8'd1;

endpackage

/* hw/rtl/lcdws_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// A read of the address written at the same edge returns the new data.
module lcdws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/char_lcd_write_sequencer.sv */
// Character LCD write sequencer: queues command/data transfers and drives an
// 8-bit parallel display bus (data, RS, E). Depends on lcdws_pkg and lcdws_ram.
//
// Each accepted item (tick, append, commit) updates state and its result is
// held in the output register the next cycle, so one item per clock is
// sustained; the only back-pressure is a result still waiting under out_stall.
// Character bytes live in a QUEUE_DEPTH*MAX_CHARS byte RAM and transfer
// headers in a QUEUE_DEPTH entry RAM; both are read one item ahead from the
// next-state pointers, so the registered read is ready when needed. Neither
// RAM is cleared after reset: entries are read only after they are written.
// Display timing is counted in tick items, not clock cycles.
`include "assert_macros.svh"

module char_lcd_write_sequencer #(
    parameter int QUEUE_DEPTH = lcdws_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_CHARS   = lcdws_pkg::DEF_MAX_CHARS,
    parameter int COUNT_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcdws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcdws_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [lcdws_pkg::BYTE_W-1:0]     data_byte,
    input  logic [lcdws_pkg::BYTE_W-1:0]     command_byte,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lcdws_pkg::BYTE_W-1:0]     bus_data,
    output logic                             reg_select,
    output logic                             enable_line,
    output logic                             busy_res,
    output logic [COUNT_W-1:0]               queued_entries,
    output logic                             dropped
);

    import lcdws_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int HDR_W  = BYTE_W + LEN_W;
    localparam int STORE_DEPTH = QUEUE_DEPTH * MAX_CHARS;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (({1'b0, s} + (SLOT_W+1)'(1)) == (SLOT_W+1)'(QUEUE_DEPTH)) ?
               '0 : s + 1'b1;
    endfunction

    // configuration
    logic [TICK_W-1:0] enable_high_reg, inst_delay_reg, clear_delay_reg;
    logic [BYTE_W-1:0] clear_cmd_reg;

    // sequencer state
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]  active_slot_reg, active_slot_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [LEN_W-1:0]   build_length_reg, build_length_next;
    logic [LEN_W-1:0]   chars_left_reg, chars_left_next;
    logic [LEN_W-1:0]   char_offset_reg, char_offset_next;
    logic [TICK_W-1:0]  tick_counter_reg, tick_counter_next;
    logic [TICK_W-1:0]  period_reg, period_next;
    logic               running_reg, running_next;
    logic [BYTE_W-1:0]  bus_reg, bus_next;
    logic               rs_reg, rs_next;
    logic               enable_reg, enable_next;
    logic               dropped_reg, dropped_next;
    logic               out_valid_reg;

    logic               in_accept;
    logic [TICK_W-1:0]  tick_inc;
    logic               start_req;
    logic [BYTE_W-1:0]  start_cmd;
    logic [LEN_W-1:0]   start_len;
    logic [TICK_W-1:0]  start_delay;

    logic               store_we;
    logic [ADDR_W-1:0]  store_waddr, store_raddr;
    logic [BYTE_W-1:0]  store_rdata;
    logic               hdr_we;
    logic [HDR_W-1:0]   hdr_wdata, hdr_rdata;
    logic [SLOT_W-1:0]  hdr_raddr;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign tick_inc  = tick_counter_reg + 1'b1;

    always_comb
    begin
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        active_slot_next  = active_slot_reg;
        entry_count_next  = entry_count_reg;
        build_length_next = build_length_reg;
        chars_left_next   = chars_left_reg;
        char_offset_next  = char_offset_reg;
        tick_counter_next = tick_counter_reg;
        period_next       = period_reg;
        running_next      = running_reg;
        bus_next          = bus_reg;
        rs_next           = rs_reg;
        enable_next       = enable_reg;
        dropped_next      = 1'b0;
        store_we          = 1'b0;
        hdr_we            = 1'b0;
        start_req         = 1'b0;
        start_cmd         = hdr_rdata[BYTE_W-1:0];
        start_len         = hdr_rdata[HDR_W-1:BYTE_W];

        if (in_accept)
        begin
            unique case (op)
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        tick_counter_next = tick_inc;
                        if (tick_inc >= enable_high_reg)
                        begin
                            enable_next = 1'b0;
                        end
                        if (tick_inc >= period_reg)
                        begin
                            if (chars_left_reg != '0)
                            begin
                                bus_next          = store_rdata;
                                rs_next           = 1'b1;
                                enable_next       = 1'b1;
                                tick_counter_next = '0;
                                chars_left_next   = chars_left_reg - 1'b1;
                                char_offset_next  = char_offset_reg + 1'b1;
                            end
                            else
                            begin
                                read_slot_next = slot_inc(read_slot_reg);
                                if (entry_count_reg != '0)
                                begin
                                    entry_count_next = entry_count_reg - 1'b1;
                                end
                                if (entry_count_reg > COUNT_W'(1))
                                begin
                                    start_req = 1'b1;
                                end
                                else
                                begin
                                    running_next      = 1'b0;
                                    enable_next       = 1'b0;
                                    tick_counter_next = '0;
                                end
                            end
                        end
                    end
                end
                OP_APPEND:
                begin
                    if ((entry_count_reg < COUNT_W'(QUEUE_DEPTH)) &&
                        (build_length_reg < LEN_W'(MAX_CHARS)))
                    begin
                        store_we          = 1'b1;
                        build_length_next = build_length_reg + 1'b1;
                    end
                end
                OP_COMMIT:
                begin
                    if (entry_count_reg == COUNT_W'(QUEUE_DEPTH))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        hdr_we           = 1'b1;
                        write_slot_next  = slot_inc(write_slot_reg);
                        entry_count_next = entry_count_reg + 1'b1;
                        if (!running_reg)
                        begin
                            start_req = 1'b1;
                            start_cmd = command_byte;
                            start_len = build_length_reg;
                        end
                    end
                    build_length_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        start_delay = (start_cmd == clear_cmd_reg) ? clear_delay_reg : inst_delay_reg;

        if (start_req)
        begin
            active_slot_next  = read_slot_next;
            chars_left_next   = start_len;
            char_offset_next  = '0;
            period_next       = (start_delay == '0) ? TICK_W'(1) : start_delay;
            tick_counter_next = '0;
            bus_next          = start_cmd;
            rs_next           = 1'b0;
            enable_next       = 1'b1;
            running_next      = 1'b1;
        end
    end

    // store reads are issued from next-state pointers so the byte is ready
    assign store_waddr = ADDR_W'(write_slot_reg) * ADDR_W'(MAX_CHARS) +
                         ADDR_W'(build_length_reg);
    assign store_raddr = ADDR_W'(active_slot_next) * ADDR_W'(MAX_CHARS) +
                         ADDR_W'(char_offset_next);
    assign hdr_wdata   = {build_length_reg, command_byte};
    assign hdr_raddr   = slot_inc(read_slot_next);

    lcdws_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_char_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (data_byte),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    lcdws_ram #(
        .WIDTH (HDR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_header (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (write_slot_reg),
        .wdata (hdr_wdata),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_high_reg <= RST_ENABLE_HIGH;
            inst_delay_reg  <= RST_INST_DELAY;
            clear_delay_reg <= RST_CLEAR_DELAY;
            clear_cmd_reg   <= RST_CLEAR_CMD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE_HIGH: enable_high_reg <= cfg_data;
                CFG_INST_DELAY:  inst_delay_reg  <= cfg_data;
                CFG_CLEAR_DELAY: clear_delay_reg <= cfg_data;
                CFG_CLEAR_CMD:   clear_cmd_reg   <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            active_slot_reg  <= '0;
            entry_count_reg  <= '0;
            build_length_reg <= '0;
            chars_left_reg   <= '0;
            char_offset_reg  <= '0;
            tick_counter_reg <= '0;
            period_reg       <= '0;
            running_reg      <= 1'b0;
            bus_reg          <= '0;
            rs_reg           <= 1'b0;
            enable_reg       <= 1'b0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                write_slot_reg   <= write_slot_next;
                read_slot_reg    <= read_slot_next;
                active_slot_reg  <= active_slot_next;
                entry_count_reg  <= entry_count_next;
                build_length_reg <= build_length_next;
                chars_left_reg   <= chars_left_next;
                char_offset_reg  <= char_offset_next;
                tick_counter_reg <= tick_counter_next;
                period_reg       <= period_next;
                running_reg      <= running_next;
                bus_reg          <= bus_next;
                rs_reg           <= rs_next;
                enable_reg       <= enable_next;
                dropped_reg      <= dropped_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign bus_data       = bus_reg;
    assign reg_select     = rs_reg;
    assign enable_line    = enable_reg;
    assign busy_res       = running_reg;
    assign queued_entries = entry_count_reg - COUNT_W'(running_reg);
    assign dropped        = dropped_reg;

    `ASSERT_CLK(a_enable_only_running, !running_reg |-> !enable_reg,
        "enable high while idle")
    `ASSERT_CLK(a_running_has_entry, running_reg |-> (entry_count_reg != '0),
        "running with empty queue")
    `ASSERT_CLK(a_count_bound, entry_count_reg <= COUNT_W'(QUEUE_DEPTH),
        "entry count above queue depth")
    `ASSERT_CLK(a_drop_only_full,
        (out_valid_reg && dropped_reg) |-> (entry_count_reg == COUNT_W'(QUEUE_DEPTH)),
        "commit dropped with room in queue")
    `ASSERT_NEXT(a_commit_starts,
        in_accept && (op == OP_COMMIT) && (entry_count_reg < COUNT_W'(QUEUE_DEPTH)),
        running_reg && !dropped_reg, "accepted commit did not start a transfer")

endmodule

/* tb/sv/lcd_bus_checker.sv */
// Checker for the character LCD write sequencer: watches the config, item and
// result channels, predicts every result and compares it field by field.
// Depends on lcdws_pkg.
module lcd_bus_checker #(
    parameter int QUEUE_DEPTH = lcdws_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_CHARS   = lcdws_pkg::DEF_MAX_CHARS,
    parameter int COUNT_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lcdws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcdws_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [lcdws_pkg::BYTE_W-1:0]     data_byte,
    input  logic [lcdws_pkg::BYTE_W-1:0]     command_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [lcdws_pkg::BYTE_W-1:0]     bus_data,
    input  logic                             reg_select,
    input  logic                             enable_line,
    input  logic                             busy_res,
    input  logic [COUNT_W-1:0]               queued_entries,
    input  logic                             dropped,
    output int                               mismatches,
    output int                               outstanding
);
    import lcdws_pkg::*;

    typedef struct packed {
        logic [7:0]         bus;
        logic               rs;
        logic               en;
        logic               busy;
        logic [COUNT_W-1:0] queued;
        logic               drop;
    } lcd_pins_t;

    logic [TICK_W-1:0] en_high, inst_dly, clr_dly;
    logic [BYTE_W-1:0] clr_cmd;

    logic [7:0]  char_mem [QUEUE_DEPTH*MAX_CHARS];
    logic [7:0]  hdr_cmd  [QUEUE_DEPTH];
    int unsigned hdr_len  [QUEUE_DEPTH];
    int unsigned wr_slot, rd_slot, n_entries, build_len;
    int unsigned act_slot, bytes_left, byte_pos;
    logic [TICK_W-1:0] ticks, period;
    logic        active;
    logic [7:0]  bus;
    logic        rs, en;

    lcd_pins_t expected_pins[$];
    int        fail_total;

    assign mismatches = fail_total;

    task automatic clear_state();
        en_high = RST_ENABLE_HIGH;
        inst_dly = RST_INST_DELAY;
        clr_dly = RST_CLEAR_DELAY;
        clr_cmd = RST_CLEAR_CMD;
        foreach (char_mem[i]) char_mem[i] = '0;
        foreach (hdr_cmd[i]) begin
            hdr_cmd[i] = '0;
            hdr_len[i] = 0;
        end
        wr_slot = 0; rd_slot = 0; n_entries = 0; build_len = 0;
        act_slot = 0; bytes_left = 0; byte_pos = 0;
        ticks = '0; period = '0; active = 1'b0;
        bus = '0; rs = 1'b0; en = 1'b0;
    endtask

    task automatic start_transfer();
        logic [7:0] c;
        c = hdr_cmd[rd_slot];
        act_slot = rd_slot;
        bytes_left = (hdr_len[rd_slot] > MAX_CHARS) ? MAX_CHARS : hdr_len[rd_slot];
        byte_pos = 0;
        period = (c == clr_cmd) ? clr_dly : inst_dly;
        if (period == '0) period = TICK_W'(1);
        ticks = '0;
        bus = c;
        rs = 1'b0;
        en = 1'b1;
        active = 1'b1;
    endtask

    task automatic close_period();
        if (bytes_left > 0) begin
            bus = char_mem[act_slot*MAX_CHARS + byte_pos];
            rs = 1'b1;
            en = 1'b1;
            ticks = '0;
            bytes_left--;
            byte_pos++;
        end else begin
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            if (n_entries > 0) n_entries--;
            if (n_entries > 0) start_transfer();
            else begin
                active = 1'b0;
                en = 1'b0;
                ticks = '0;
            end
        end
    endtask

    task automatic advance_bus(input logic [1:0] o, input logic [7:0] d, input logic [7:0] c,
                               output lcd_pins_t r);
        logic drop;
        drop = 1'b0;
        case (o)
            OP_TICK: begin
                if (active) begin
                    ticks = ticks + 1'b1;
                    if (ticks >= en_high) en = 1'b0;
                    if (ticks >= period) close_period();
                end
            end
            OP_APPEND: begin
                if (n_entries < QUEUE_DEPTH && build_len < MAX_CHARS) begin
                    char_mem[wr_slot*MAX_CHARS + build_len] = d;
                    build_len++;
                end
            end
            OP_COMMIT: begin
                if (n_entries >= QUEUE_DEPTH) drop = 1'b1;
                else begin
                    hdr_cmd[wr_slot] = c;
                    hdr_len[wr_slot] = build_len;
                    wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                    n_entries++;
                    if (!active) start_transfer();
                end
                build_len = 0;
            end
            default: ;
        endcase
        r.bus = bus;
        r.rs = rs;
        r.en = en;
        r.busy = active;
        r.queued = COUNT_W'(n_entries - ((active && n_entries > 0) ? 1 : 0));
        r.drop = drop;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        lcd_pins_t want, pred;
        if (!rst_n) begin
            clear_state();
            expected_pins.delete();
            fail_total = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLE_HIGH: en_high = cfg_data;
                    CFG_INST_DELAY:  inst_dly = cfg_data;
                    CFG_CLEAR_DELAY: clr_dly = cfg_data;
                    CFG_CLEAR_CMD:   clr_cmd = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_pins.size() == 0) begin
                    $error("result transaction with no expected result pending");
                    fail_total++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("bus_data", 16'(want.bus), 16'(bus_data));
                    check_field("reg_select", 16'(want.rs), 16'(reg_select));
                    check_field("enable_line", 16'(want.en), 16'(enable_line));
                    check_field("busy_res", 16'(want.busy), 16'(busy_res));
                    check_field("queued_entries", 16'(want.queued), 16'(queued_entries));
                    check_field("dropped", 16'(want.drop), 16'(dropped));
                end
            end
            if (in_valid && !in_stall) begin
                advance_bus(op, data_byte, command_byte, pred);
                expected_pins.push_back(pred);
            end
            outstanding <= expected_pins.size();
        end
    end
endmodule

/* tb/sv/tb.sv */
// Top of the char_lcd_write_sequencer testbench: clock, reset, stimulus, stall
// patterns, watchdog and verdict. Depends on lcdws_pkg, lcd_bus_checker and
// the RTL of char_lcd_write_sequencer.
module tb;
    import lcdws_pkg::*;

    localparam int CNT_W      = $clog2(DEF_QUEUE_DEPTH + 1);
    localparam int QUIET_MAX  = 4000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            op = OP_TICK;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic [BYTE_W-1:0]     command_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     bus_data;
    logic                  reg_select;
    logic                  enable_line;
    logic                  busy_res;
    logic [CNT_W-1:0]      queued_entries;
    logic                  dropped;

    int mismatches, outstanding;
    int quiet_cycles = 0;
    int results_taken = 0;
    int burst_left = 0;
    int items_sent = 0;
    int commits_sent = 0;
    int phase_cnt = 0;
    int hold_left = 0;
    int mode = 0;
    int mode_left = 0;
    bit hold_done = 1'b0;

    logic [TICK_W-1:0] cur_inst, cur_clr;
    logic [BYTE_W-1:0] cur_clr_cmd;

    always #5 clk = ~clk;

    char_lcd_write_sequencer DUT (.*);

    lcd_bus_checker u_check (.*);

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) results_taken <= results_taken + 1;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_MAX) begin
                $display("char_lcd_write_sequencer: mismatch");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall modes, plus one long hold to back the block up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_stall <= 1'b0;
        else begin
            if (!hold_done && results_taken >= 700) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] d, input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op <= o;
        data_byte <= d;
        command_byte <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
        if (o == OP_COMMIT) commits_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] en_t, input logic [15:0] inst_t,
                              input logic [15:0] clr_t, input logic [7:0] clr_c);
        drain();
        write_reg(CFG_ENABLE_HIGH, en_t);
        write_reg(CFG_INST_DELAY, inst_t);
        write_reg(CFG_CLEAR_DELAY, clr_t);
        write_reg(CFG_CLEAR_CMD, {8'h00, clr_c});
        cfg_valid <= 1'b0;
        cur_inst = inst_t;
        cur_clr = clr_t;
        cur_clr_cmd = clr_c;
        phase_cnt++;
    endtask

    // one transfer: appends, commit, then roughly enough ticks to play it out, at most cap
    task automatic send_transfer(input int cap);
        int n, r, lo, hi, per;
        logic [7:0] cmd;
        r = $urandom_range(0, 9);
        n = (r < 6) ? $urandom_range(0, 4) : (r < 9) ? $urandom_range(5, 20)
                                                     : $urandom_range(21, 24);
        repeat (n) send_item(OP_APPEND, 8'($urandom), 8'($urandom));
        cmd = ($urandom_range(0, 3) == 0) ? cur_clr_cmd : 8'($urandom);
        send_item(OP_COMMIT, 8'($urandom), cmd);
        per = int'((cmd == cur_clr_cmd) ? cur_clr : cur_inst);
        if (per == 0) per = 1;
        if (n > DEF_MAX_CHARS) n = DEF_MAX_CHARS;
        lo = (n + 1) * per / 2;
        hi = (n + 1) * per * 3 / 2 + 1;
        if (lo > cap) lo = cap;
        if (hi > cap) hi = cap;
        repeat ($urandom_range(lo, hi)) send_item(OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic run_random(input int count, input int cap);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            else
                send_transfer(cap);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_timing(16'd1, 16'd2, 16'd3, 8'h01);
        send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        send_item(OP_COMMIT, 8'hFF, 8'h00);
        repeat (3) send_item(OP_TICK, 8'hFF, 8'h00);
        send_item(OP_APPEND, 8'hFF, 8'h00);
        send_item(OP_APPEND, 8'h00, 8'hFF);
        send_item(OP_COMMIT, 8'h00, 8'hFF);
        send_item(OP_COMMIT, 8'h00, 8'h01);
        repeat (8) send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_APPEND, 8'hA5, 8'h00);
        send_item(OP_COMMIT, 8'h00, 8'h01);
        repeat (6) send_item(OP_TICK, 8'h00, 8'h00);
        run_random(300, 60);

        set_timing(16'd0, 16'd1, 16'd1, 8'h00);
        run_random(300, 60);
        set_timing(16'hFFFF, 16'd3, 16'd5, 8'hFF);
        run_random(300, 60);
        set_timing(16'd2, 16'd0, 16'd0, 8'h80);
        run_random(280, 60);
        set_timing(16'd7, 16'd4, 16'd9, 8'h20);
        run_random(280, 80);
        // huge periods: the queue fills, later commits are dropped
        set_timing(16'd3, 16'hFFFF, 16'hFFFF, 8'h00);
        run_random(470, 0);

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d items (%0d commits) over %0d timing settings, %0d results checked",
                 items_sent, commits_sent, phase_cnt, results_taken);
        if (mismatches == 0)
            $display("char_lcd_write_sequencer: match");
        else
            $display("char_lcd_write_sequencer: mismatch");
        $finish;
    end
endmodule
